### hw/rtl/lie_pkg.sv
// Package for the Lagrange interpolation evaluator: payload structs,
// status codes, controller/datapath command and status structs.
// No dependencies.
package lie_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int FRAC_BITS_DEF = 24;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] NODES_RST = 5'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [0:0] ADDR_NODES = 1'b0;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  slot;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] query_x;
    } t_req;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } t_rsp;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1, // clear accumulator, latch query point
        OP_TERM    = 3'd2, // term = 1.0, latch x_i
        OP_MULNUM  = 3'd3, // term *= (x - x_j), start divide
        OP_MULY    = 3'd4, // term *= y_i
        OP_ACC     = 3'd5  // acc += term
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic dup;       // x_i == x_j seen
    } t_sts;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)       r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
        else                           r = {1'b0, v[31:0]};
        return r;
    endfunction

    // Signed value from magnitude and sign, saturating; bit 32 flags saturation.
    function automatic logic [32:0] from_mag(input logic [63:0] m, input logic neg);
        logic [32:0] r;
        if (neg) begin
            if (m > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
            else                   r = {1'b0, 32'(64'd0 - m)};
        end else begin
            if (m > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else                   r = {1'b0, m[31:0]};
        end
        return r;
    endfunction

endpackage

### hw/rtl/lie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/lie_div.sv
// Radix-2 restoring divider, unsigned magnitude, one quotient bit per cycle.
// Depends on lie_pkg for nothing; standalone.
module lie_div #(
    parameter int NW = 56, // numerator width
    parameter int DW = 33  // denominator width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW:0]   w_sh;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        w_sh  = {r_rem[DW-1:0], r_quo[NW-1]};
        if (r_cnt != '0) begin
            n_quo = {r_quo[NW-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem    = w_sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0) || i_start;
    assign o_quo  = r_quo;
endmodule

### hw/rtl/lie_dp.sv
// Datapath: node memories, difference/multiply/divide/accumulate registers.
// Depends on lie_pkg, lie_ram, lie_div.
module lie_dp #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = lie_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [AW-1:0]      i_load_slot,
    input  logic [31:0]        i_load_x,
    input  logic [31:0]        i_load_y,
    input  logic [31:0]        i_query_x,
    input  logic [AW-1:0]      i_raddr,
    input  lie_pkg::t_cmd      i_cmd,
    output lie_pkg::t_sts      o_sts,
    output logic [31:0]        o_acc,
    output logic               o_sat
);
    localparam int NW = 32 + FRAC_BITS;

    logic [31:0] w_xr, w_yr;
    logic signed [31:0] r_x, r_xi, r_term, r_acc;
    logic r_sat, r_neg;
    logic r_div_pend;

    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xram (
        .i_clk, .i_we(i_load), .i_waddr(i_load_slot), .i_wdata(i_load_x),
        .i_raddr, .o_rdata(w_xr));
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_yram (
        .i_clk, .i_we(i_load), .i_waddr(i_load_slot), .i_wdata(i_load_y),
        .i_raddr, .o_rdata(w_yr));

    // Differences and product for a multiply-by-numerator step.
    logic [32:0] w_num, w_den, w_mul, w_q, w_sum;
    logic signed [31:0] w_numv, w_denv, w_mop;
    logic [63:0] w_mag_t, w_mag_o, w_prod;
    logic [NW-1:0] w_dnum, w_quo;
    logic [32:0] w_dden;
    logic w_start, w_busy;

    always_comb begin
        w_num  = lie_pkg::sat32(64'(signed'(r_x)) - 64'(signed'(w_xr)));
        w_den  = lie_pkg::sat32(64'(signed'(r_xi)) - 64'(signed'(w_xr)));
        w_numv = w_num[31:0];
        w_denv = w_den[31:0];
        w_mop  = (i_cmd.op == lie_pkg::OP_MULY) ? signed'(w_yr) : w_numv;
        w_mag_t = r_term[31] ? 64'(-64'(signed'(r_term))) : 64'(r_term);
        w_mag_o = w_mop[31] ? 64'(-64'(signed'(w_mop))) : 64'(w_mop);
        w_prod  = (w_mag_t[32:0] * w_mag_o[32:0]) >> FRAC_BITS;
        w_mul   = lie_pkg::from_mag(w_prod, r_term[31] ^ w_mop[31]);
        // Divide the product just formed by the denominator.
        w_dnum  = NW'(w_mul[31] ? 64'(-64'(signed'(w_mul[31:0]))) : 64'(w_mul[31:0]))
                  << FRAC_BITS;
        w_dden  = w_denv[31] ? 33'(-34'(signed'(w_denv))) : 33'(w_denv);
        w_start = (i_cmd.op == lie_pkg::OP_MULNUM);
        w_q     = lie_pkg::from_mag(64'(w_quo), r_neg);
        w_sum   = lie_pkg::sat32(64'(signed'(r_acc)) + 64'(signed'(r_term)));
    end

    lie_div #(.NW(NW), .DW(33)) u_div (
        .i_clk, .i_rst_n, .i_start(w_start), .i_num(w_dnum), .i_den(w_dden),
        .o_busy(w_busy), .o_quo(w_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_pend <= 1'b0;
        end else begin
            if (w_start) r_div_pend <= 1'b1;
            else if (!w_busy) r_div_pend <= 1'b0;
        end
        if (r_div_pend && !w_busy) begin
            r_term <= w_q[31:0];
            if (w_q[32]) r_sat <= 1'b1;
        end
        unique case (i_cmd.op)
            lie_pkg::OP_START: begin
                r_x   <= i_query_x;
                r_acc <= '0;
                r_sat <= 1'b0;
            end
            lie_pkg::OP_TERM: begin
                r_xi   <= w_xr;
                r_term <= 32'sd1 <<< FRAC_BITS;
            end
            lie_pkg::OP_MULNUM: begin
                r_neg <= w_mul[31] ^ w_denv[31];
                if (w_num[32] | w_den[32] | w_mul[32]) r_sat <= 1'b1;
            end
            lie_pkg::OP_MULY: begin
                r_term <= w_mul[31:0];
                if (w_mul[32]) r_sat <= 1'b1;
            end
            lie_pkg::OP_ACC: begin
                r_acc <= w_sum[31:0];
                if (w_sum[32]) r_sat <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_sts.div_busy = w_busy || r_div_pend;
    assign o_sts.dup      = (w_xr == r_xi);
    assign o_acc          = r_acc;
    assign o_sat          = r_sat;
endmodule

### hw/rtl/lie_ctrl.sv
// Controller: sequences node reads and datapath operations for a query.
// Depends on lie_pkg.
module lie_ctrl #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF,
    localparam int AW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_query,
    input  logic [lie_pkg::CFG_W-1:0] i_nodes,
    input  lie_pkg::t_sts        i_sts,
    input  logic                 i_out_free,
    output logic                 o_busy,
    output logic [AW-1:0]        o_raddr,
    output lie_pkg::t_cmd        o_cmd,
    output logic                 o_done,
    output logic                 o_zdiv
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RDI  = 8'b0000_0010,
        S_TERM = 8'b0000_0100,
        S_RDJ  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MULY = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_n, r_i, r_j, n_i, n_j;
    logic [CW-1:0] w_ncl;
    logic r_zdiv, n_zdiv;

    assign w_ncl = (32'(i_nodes) > MAX_NODES) ? CW'(MAX_NODES) : CW'(i_nodes);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_zdiv   = r_zdiv;
        o_cmd.op = lie_pkg::OP_NONE;
        o_raddr  = r_i[AW-1:0];
        o_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    o_cmd.op = lie_pkg::OP_START;
                    n_i = '0;
                    n_zdiv = 1'b0;
                    n_state = (w_ncl == '0) ? S_DONE : S_RDI;
                end
            end
            S_RDI: begin
                o_raddr = r_i[AW-1:0];
                n_state = S_TERM;
            end
            S_TERM: begin
                o_cmd.op = lie_pkg::OP_TERM;
                n_j = '0;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                o_raddr = r_j[AW-1:0];
                if (r_j == r_n) begin
                    o_raddr = r_i[AW-1:0];
                    n_state = S_MULY;
                end else if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_raddr = r_j[AW-1:0];
                if (i_sts.dup) begin
                    n_zdiv = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = lie_pkg::OP_MULNUM;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_j = r_j + 1'b1;
                    n_state = S_RDJ;
                end
            end
            S_MULY: begin
                o_raddr = r_i[AW-1:0];
                o_cmd.op = lie_pkg::OP_MULY;
                n_i = r_i + 1'b1;
                n_state = S_DONE;
                if (r_i + 1'b1 != r_n) n_state = S_RDI;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_zdiv <= n_zdiv;
        if (r_state == S_IDLE) r_n <= w_ncl;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_zdiv = r_zdiv;
endmodule

### hw/rtl/lagrange_interpolation_eval.sv
// Lagrange interpolation evaluator, top level: APB register, request/result
// channels, controller and datapath. Depends on lie_pkg, lie_ctrl, lie_dp.
//
// A query with n nodes runs n*(n-1) multiply/divide steps on one shared
// radix-2 divider, and the divider loop dominates the time a query takes.
// A duplicate abscissa stops the query early with status 1. A new request is
// taken while a result waits; a finished query holds until the result
// register is free, and the request side stays closed meanwhile.
module lagrange_interpolation_eval #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = lie_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lie_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output lie_pkg::t_rsp  o_rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [0:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    localparam int AW = $clog2(MAX_NODES);

    logic [lie_pkg::CFG_W-1:0] r_nodes;
    logic r_ovalid;
    lie_pkg::t_rsp r_rsp;
    logic w_acc_in, w_load, w_query, w_busy, w_done, w_zdiv, w_sat, w_free;
    logic [AW-1:0] w_raddr;
    lie_pkg::t_cmd w_cmd, w_dcmd;
    lie_pkg::t_sts w_sts;
    logic [31:0] w_acc;
    logic r_acc_pend;

    assign pready = 1'b1;
    assign prdata = (paddr[0] == lie_pkg::ADDR_NODES) ? 32'(r_nodes) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= lie_pkg::NODES_RST;
        end else if (psel && penable && pwrite && paddr[0] == lie_pkg::ADDR_NODES) begin
            r_nodes <= pwdata[lie_pkg::CFG_W-1:0];
        end
    end

    assign o_ready  = !w_busy && !r_acc_pend;
    assign w_acc_in = i_valid && o_ready;
    assign w_load   = w_acc_in && i_req.req_type == lie_pkg::REQ_LOAD &&
                      32'(i_req.slot) < MAX_NODES;
    assign w_query  = w_acc_in && i_req.req_type == lie_pkg::REQ_QUERY;
    assign w_free   = !r_ovalid || i_ready;

    lie_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .i_clk, .i_rst_n, .i_query(w_query), .i_nodes(r_nodes), .i_sts(w_sts),
        .i_out_free(w_free && !r_acc_pend), .o_busy(w_busy), .o_raddr(w_raddr),
        .o_cmd(w_cmd), .o_done(w_done), .o_zdiv(w_zdiv));

    // Issue the accumulate in the cycle after the ordinate multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_acc_pend <= 1'b0;
        else          r_acc_pend <= (w_cmd.op == lie_pkg::OP_MULY);
    end
    assign w_dcmd.op = r_acc_pend ? lie_pkg::OP_ACC : w_cmd.op;

    lie_dp #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_load(w_load), .i_load_slot(i_req.slot[AW-1:0]),
        .i_load_x(i_req.node_x), .i_load_y(i_req.node_y),
        .i_query_x(i_req.query_x), .i_raddr(w_raddr), .i_cmd(w_dcmd),
        .o_sts(w_sts), .o_acc(w_acc), .o_sat(w_sat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_done) begin
            r_rsp.interp_value <= w_zdiv ? '0 : w_acc;
            r_rsp.status <= w_zdiv ? lie_pkg::ST_ZDIV :
                            (w_sat ? lie_pkg::ST_SAT : lie_pkg::ST_OK);
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
endmodule

### hw/rtl/lie_chk.sv
// Port-level checker for the interpolation evaluator, bound to the top.
// Depends on lie_pkg.
module lie_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input lie_pkg::t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result dropped while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status != 2'd3)
        else $error("bad status code");
    a_zdiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == lie_pkg::ST_ZDIV |-> o_rsp.interp_value == '0)
        else $error("zero divisor with nonzero value");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result without a query in flight");
endmodule

bind lagrange_interpolation_eval lie_chk u_chk (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready, .o_rsp);
